// File: hw/rtl/sqs_pkg.sv
package sqs_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int SCORE_BITS    = 32;
    localparam int SUM_BITS      = 48;

    localparam int QUAD_LEN   = 4;
    localparam int HIST_LEN   = QUAD_LEN - 1;
    localparam int HCNT_W     = $clog2(QUAD_LEN);
    localparam int LETTER_W   = 5;
    localparam int INDEX_W    = 19;
    localparam int VALUE_W    = 32;
    localparam int OUT_SCORE_W = 48;
    localparam int KEY_W      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int ALPHA2     = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ALPHA3     = ALPHA2 * ALPHABET_SIZE;
    localparam int QUAD_DEPTH = ALPHA3 * ALPHABET_SIZE;
    localparam int QUAD_W     = $clog2(QUAD_DEPTH);
    localparam int ADD_W      = ((SUM_BITS > SCORE_BITS) ? SUM_BITS : SCORE_BITS) + 1;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        OP_KEY_WR     = 2'd0,
        OP_SCORE_WR   = 2'd1,
        OP_TEXT       = 2'd2,
        OP_CLEAR_BEST = 2'd3
    } opcode_t;

    typedef struct packed {
        logic                valid;
        opcode_t             op;
        logic [LETTER_W-1:0] plain;
        logic                last;
        logic                score_en;
    } stage_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [QUAD_W-1:0]     addr;
        logic [SCORE_BITS-1:0] wdata;
    } ram_req_t;

endpackage

// File: hw/rtl/substitution_quadgram_scorer.sv
// A request passes the input registers, the stage register and the output registers.
// Throughput: one request per cycle unless the output stalls; the score memory takes
// one read or write per cycle. Reset clears control state, then the score memory is
// zeroed one entry per cycle over all 456976 entries for a 26-letter alphabet;
// s_axis_tready stays low meanwhile. The substitution key is undefined until written.
module substitution_quadgram_scorer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // table_index [18:0], table_value [50:19], letter [55:51]
    input  logic [sqs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode [1:0]
    input  logic [1:0]                         s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // plain_letter [4:0], running_score [52:5], zero fill [55:53]
    output logic [sqs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // is_better [0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);

    logic                                en;
    logic                                clr_busy_reg;
    logic [sqs_pkg::QUAD_W-1:0]          clr_addr_reg;
    sqs_pkg::ram_req_t                   ram_req;
    sqs_pkg::stage_t                     stage;
    logic                                ram_we;
    logic [sqs_pkg::QUAD_W-1:0]          ram_addr;
    logic [sqs_pkg::SCORE_BITS-1:0]      ram_wdata;
    logic [sqs_pkg::SCORE_BITS-1:0]      ram_rdata;
    logic [sqs_pkg::LETTER_W-1:0]        out_plain;
    logic [sqs_pkg::OUT_SCORE_W-1:0]     out_score;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && !clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == sqs_pkg::QUAD_W'(sqs_pkg::QUAD_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign ram_we    = clr_busy_reg || ram_req.we;
    assign ram_addr  = clr_busy_reg ? clr_addr_reg : ram_req.addr;
    assign ram_wdata = clr_busy_reg ? '0 : ram_req.wdata;

    sqs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid && s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_index  (s_axis_tdata[18:0]),
        .in_value  (s_axis_tdata[50:19]),
        .in_letter (s_axis_tdata[55:51]),
        .in_last   (s_axis_tlast),
        .ram_req   (ram_req),
        .stage     (stage)
    );

    sqs_ram #(
        .WIDTH (sqs_pkg::SCORE_BITS),
        .DEPTH (sqs_pkg::QUAD_DEPTH)
    ) u_score_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_req.re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    sqs_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .stage      (stage),
        .rdata      (ram_rdata),
        .out_valid  (m_axis_tvalid),
        .out_plain  (out_plain),
        .out_score  (out_score),
        .out_better (m_axis_tuser),
        .out_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_score, out_plain};

    // No request may enter while the score memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_axis_tready)
        else $error("request accepted during score memory clear");

    // The clearing pass runs once after reset and never restarts.
    assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy_reg |=> !clr_busy_reg)
        else $error("score memory clear restarted");

    // A new best total can only be reported at the end of a pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("better flag outside the last letter of a pass");

endmodule

// File: hw/rtl/sqs_ram.sv
module sqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/sqs_front.sv
module sqs_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [1:0]                            in_op,
    input  logic [sqs_pkg::INDEX_W-1:0]           in_index,
    input  logic [sqs_pkg::VALUE_W-1:0]           in_value,
    input  logic [sqs_pkg::LETTER_W-1:0]          in_letter,
    input  logic                                  in_last,
    output sqs_pkg::ram_req_t                     ram_req,
    output sqs_pkg::stage_t                       stage
);

    logic                           s1_valid_reg;
    sqs_pkg::opcode_t               s1_op_reg;
    logic [sqs_pkg::INDEX_W-1:0]    s1_index_reg;
    logic [sqs_pkg::VALUE_W-1:0]    s1_value_reg;
    logic [sqs_pkg::LETTER_W-1:0]   s1_letter_reg;
    logic                           s1_last_reg;

    logic [sqs_pkg::LETTER_W-1:0]   key_reg [sqs_pkg::ALPHABET_SIZE];
    logic [sqs_pkg::LETTER_W-1:0]   hist_reg [sqs_pkg::HIST_LEN];
    logic [sqs_pkg::HCNT_W-1:0]     hcnt_reg;
    logic [sqs_pkg::HCNT_W-1:0]     hcnt_next;
    sqs_pkg::stage_t                stage_reg;
    sqs_pkg::stage_t                stage_next;

    logic                           is_text;
    logic                           key_wr;
    logic                           score_wr;
    logic [sqs_pkg::LETTER_W-1:0]   plain;
    logic                           quad_ok;
    logic [sqs_pkg::QUAD_W-1:0]     quad_idx;

    assign is_text  = s1_valid_reg && (s1_op_reg == sqs_pkg::OP_TEXT);
    assign key_wr   = s1_valid_reg && (s1_op_reg == sqs_pkg::OP_KEY_WR)
                      && (s1_index_reg < sqs_pkg::ALPHABET_SIZE);
    assign score_wr = s1_valid_reg && (s1_op_reg == sqs_pkg::OP_SCORE_WR)
                      && (s1_index_reg < sqs_pkg::QUAD_DEPTH);

    always_comb
    begin
        if (s1_letter_reg < sqs_pkg::ALPHABET_SIZE)
        begin
            plain = key_reg[s1_letter_reg[sqs_pkg::KEY_W-1:0]];
        end
        else
        begin
            plain = '0;
        end
    end

    assign quad_ok = (hcnt_reg == sqs_pkg::HCNT_W'(sqs_pkg::HIST_LEN))
                     && (hist_reg[0] < sqs_pkg::ALPHABET_SIZE)
                     && (hist_reg[1] < sqs_pkg::ALPHABET_SIZE)
                     && (hist_reg[2] < sqs_pkg::ALPHABET_SIZE)
                     && (plain < sqs_pkg::ALPHABET_SIZE);

    assign quad_idx = sqs_pkg::QUAD_W'(hist_reg[0]) * sqs_pkg::QUAD_W'(sqs_pkg::ALPHA3)
                    + sqs_pkg::QUAD_W'(hist_reg[1]) * sqs_pkg::QUAD_W'(sqs_pkg::ALPHA2)
                    + sqs_pkg::QUAD_W'(hist_reg[2]) * sqs_pkg::QUAD_W'(sqs_pkg::ALPHABET_SIZE)
                    + sqs_pkg::QUAD_W'(plain);

    always_comb
    begin
        ram_req.we    = en && score_wr;
        ram_req.re    = en && is_text;
        ram_req.addr  = score_wr ? sqs_pkg::QUAD_W'(s1_index_reg) : quad_idx;
        ram_req.wdata = sqs_pkg::SCORE_BITS'(s1_value_reg);
    end

    always_comb
    begin
        hcnt_next = hcnt_reg;
        if (s1_last_reg)
        begin
            hcnt_next = '0;
        end
        else if (hcnt_reg != sqs_pkg::HCNT_W'(sqs_pkg::HIST_LEN))
        begin
            hcnt_next = hcnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        stage_next.valid    = s1_valid_reg;
        stage_next.op       = s1_op_reg;
        stage_next.plain    = plain;
        stage_next.last     = s1_last_reg;
        stage_next.score_en = quad_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hcnt_reg     <= '0;
            stage_reg    <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            stage_reg    <= stage_next;
            if (is_text)
            begin
                hcnt_reg <= hcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg     <= sqs_pkg::opcode_t'(in_op);
            s1_index_reg  <= in_index;
            s1_value_reg  <= in_value;
            s1_letter_reg <= in_letter;
            s1_last_reg   <= in_last;
            if (is_text)
            begin
                hist_reg[0] <= hist_reg[1];
                hist_reg[1] <= hist_reg[2];
                hist_reg[2] <= plain;
            end
            if (key_wr)
            begin
                key_reg[s1_index_reg[sqs_pkg::KEY_W-1:0]] <= s1_letter_reg;
            end
        end
    end

    assign stage = stage_reg;

endmodule

// File: hw/rtl/sqs_accum.sv
module sqs_accum (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  sqs_pkg::stage_t                       stage,
    input  logic [sqs_pkg::SCORE_BITS-1:0]        rdata,
    output logic                                  out_valid,
    output logic [sqs_pkg::LETTER_W-1:0]          out_plain,
    output logic [sqs_pkg::OUT_SCORE_W-1:0]       out_score,
    output logic                                  out_better,
    output logic                                  out_done
);

    logic [sqs_pkg::SUM_BITS-1:0]     sum_reg;
    logic [sqs_pkg::SUM_BITS-1:0]     best_reg;
    logic                             out_valid_reg;
    logic [sqs_pkg::LETTER_W-1:0]     out_plain_reg;
    logic [sqs_pkg::OUT_SCORE_W-1:0]  out_score_reg;
    logic                             out_better_reg;
    logic                             out_done_reg;

    logic                             is_text;
    logic                             is_clear;
    logic [sqs_pkg::SCORE_BITS-1:0]   addend;
    logic [sqs_pkg::ADD_W-1:0]        raw_sum;
    logic [sqs_pkg::SUM_BITS-1:0]     sum_next;
    logic                             better;

    assign is_text  = stage.valid && (stage.op == sqs_pkg::OP_TEXT);
    assign is_clear = stage.valid && (stage.op == sqs_pkg::OP_CLEAR_BEST);
    assign addend   = stage.score_en ? rdata : '0;
    assign raw_sum  = sqs_pkg::ADD_W'(sum_reg) + sqs_pkg::ADD_W'(addend);

    always_comb
    begin
        if (raw_sum[sqs_pkg::ADD_W-1:sqs_pkg::SUM_BITS] != '0)
        begin
            sum_next = '1;
        end
        else
        begin
            sum_next = raw_sum[sqs_pkg::SUM_BITS-1:0];
        end
    end

    assign better = stage.last && (sum_next > best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= is_text;
            if (is_text)
            begin
                sum_reg <= stage.last ? '0 : sum_next;
                if (better)
                begin
                    best_reg <= sum_next;
                end
            end
            else if (is_clear)
            begin
                best_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_plain_reg  <= stage.plain;
            out_score_reg  <= sqs_pkg::OUT_SCORE_W'(sum_next);
            out_better_reg <= better;
            out_done_reg   <= stage.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_plain  = out_plain_reg;
    assign out_score  = out_score_reg;
    assign out_better = out_better_reg;
    assign out_done   = out_done_reg;

endmodule

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sqs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [LETTER_W-1:0]    plain_letter;
        logic [OUT_SCORE_W-1:0] running_score;
        logic                   is_better;
        logic                   pass_done;
    } letter_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = OP_TEXT;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // Scorer state as predicted from the accepted requests.
    logic [LETTER_W-1:0]   key_letters [ALPHABET_SIZE];
    logic [SCORE_BITS-1:0] quad_scores [int unsigned];
    logic [LETTER_W-1:0]   recent_plain [HIST_LEN];
    int unsigned           recent_count;
    logic [SUM_BITS-1:0]   pass_total;
    logic [SUM_BITS-1:0]   kept_best_total;

    letter_result_t        pending_letters [$];
    letter_result_t        oldest_letter;

    int unsigned cycle_count;
    int unsigned requests_sent;
    int unsigned letters_checked;
    int unsigned passes_checked;
    int unsigned new_best_count;
    int unsigned error_count;
    bit          source_busy;
    bit          sink_busy;
    int unsigned sink_ready_run;
    int unsigned sink_stall_left;

    substitution_quadgram_scorer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned pick_gap(input bit busy);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!busy || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (sink_ready_run > 0)
        begin
            m_axis_tready <= 1'b1;
            sink_ready_run--;
        end
        else if (sink_stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            sink_ready_run = $urandom_range(0, 15);
            sink_stall_left = pick_gap(sink_busy);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_letters.size());
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_letters.size() == 0)
            begin
                $display("%0t: unexpected result, actual tdata=%h tuser=%b tlast=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end
            else
            begin
                oldest_letter = pending_letters.pop_front();
                letters_checked++;
                if (m_axis_tlast)
                    passes_checked++;
                if (m_axis_tuser)
                    new_best_count++;
                if (m_axis_tdata[4:0] !== oldest_letter.plain_letter)
                begin
                    $display("%0t: plain_letter expected %0d actual %0d",
                             $time, oldest_letter.plain_letter, m_axis_tdata[4:0]);
                    error_count++;
                end
                if (m_axis_tdata[52:5] !== oldest_letter.running_score)
                begin
                    $display("%0t: running_score expected %h actual %h",
                             $time, oldest_letter.running_score, m_axis_tdata[52:5]);
                    error_count++;
                end
                if (m_axis_tdata[55:53] !== 3'b000)
                begin
                    $display("%0t: zero fill expected 0 actual %b", $time, m_axis_tdata[55:53]);
                    error_count++;
                end
                if (m_axis_tuser !== oldest_letter.is_better)
                begin
                    $display("%0t: is_better expected %b actual %b",
                             $time, oldest_letter.is_better, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tlast !== oldest_letter.pass_done)
                begin
                    $display("%0t: pass_done expected %b actual %b",
                             $time, oldest_letter.pass_done, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [LETTER_W-1:0] decrypt_letter(input logic [LETTER_W-1:0] cipher);
        return (cipher < ALPHABET_SIZE) ? key_letters[cipher] : '0;
    endfunction

    function automatic int unsigned quad_address(input logic [LETTER_W-1:0] a,
                                                 input logic [LETTER_W-1:0] b,
                                                 input logic [LETTER_W-1:0] c,
                                                 input logic [LETTER_W-1:0] d);
        return ((a * ALPHABET_SIZE + b) * ALPHABET_SIZE + c) * ALPHABET_SIZE + d;
    endfunction

    function automatic logic [SCORE_BITS-1:0] quad_lookup(input logic [LETTER_W-1:0] newest);
        int unsigned addr;
        if (recent_plain[0] >= ALPHABET_SIZE || recent_plain[1] >= ALPHABET_SIZE ||
            recent_plain[2] >= ALPHABET_SIZE || newest >= ALPHABET_SIZE)
            return '0;
        addr = quad_address(recent_plain[0], recent_plain[1], recent_plain[2], newest);
        return quad_scores.exists(addr) ? quad_scores[addr] : '0;
    endfunction

    task automatic apply_request(input opcode_t op, input logic [INDEX_W-1:0] index,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [LETTER_W-1:0] letter, input logic last);
        letter_result_t      result;
        logic [LETTER_W-1:0] plain;
        logic [SUM_BITS:0]   wide_sum;
        case (op)
            OP_KEY_WR:
            begin
                if (index < ALPHABET_SIZE)
                    key_letters[index] = letter;
            end
            OP_SCORE_WR:
            begin
                if (index < QUAD_DEPTH)
                    quad_scores[index] = value[SCORE_BITS-1:0];
            end
            OP_CLEAR_BEST:
                kept_best_total = '0;
            default:
            begin
                plain = decrypt_letter(letter);
                if (recent_count >= HIST_LEN)
                begin
                    wide_sum = {1'b0, pass_total} + quad_lookup(plain);
                    pass_total = wide_sum[SUM_BITS] ? '1 : wide_sum[SUM_BITS-1:0];
                end
                else
                    recent_count++;
                recent_plain[0] = recent_plain[1];
                recent_plain[1] = recent_plain[2];
                recent_plain[2] = plain;
                result.plain_letter = plain;
                result.running_score = pass_total[OUT_SCORE_W-1:0];
                result.is_better = 1'b0;
                result.pass_done = last;
                if (last)
                begin
                    if (pass_total > kept_best_total)
                    begin
                        kept_best_total = pass_total;
                        result.is_better = 1'b1;
                    end
                    recent_plain = '{default: '0};
                    recent_count = 0;
                    pass_total = '0;
                end
                pending_letters.push_back(result);
            end
        endcase
    endtask

    task automatic send_request(input opcode_t op, input logic [INDEX_W-1:0] index,
                                input logic [VALUE_W-1:0] value,
                                input logic [LETTER_W-1:0] letter, input logic last);
        int unsigned gap;
        gap = pick_gap(source_busy);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {letter, value, index};
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(op, index, value, letter, last);
        requests_sent++;
    endtask

    task automatic send_text(input logic [LETTER_W-1:0] cipher, input logic last);
        send_request(OP_TEXT, INDEX_W'($urandom), $urandom, cipher, last);
    endtask

    task automatic send_key(input int unsigned cipher, input logic [LETTER_W-1:0] plain);
        send_request(OP_KEY_WR, INDEX_W'(cipher), $urandom, plain, 1'($urandom));
    endtask

    task automatic send_score(input int unsigned addr, input logic [VALUE_W-1:0] value);
        send_request(OP_SCORE_WR, INDEX_W'(addr), value, LETTER_W'($urandom), 1'($urandom));
    endtask

    task automatic send_clear_best();
        send_request(OP_CLEAR_BEST, INDEX_W'($urandom), $urandom, LETTER_W'($urandom),
                     1'($urandom));
    endtask

    function automatic logic [LETTER_W-1:0] random_cipher();
        return ($urandom_range(0, 99) < 95) ? LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1))
                                            : LETTER_W'($urandom_range(ALPHABET_SIZE, 31));
    endfunction

    function automatic logic [VALUE_W-1:0] random_score();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '1;
        if (roll < 30)
            return $urandom_range(0, 255);
        return $urandom;
    endfunction

    task automatic load_full_key();
        for (int unsigned i = 0; i < ALPHABET_SIZE; i++)
            send_key(i, random_cipher());
    endtask

    // Writes scores for some quadgrams of the pass so that sums move, then sends the pass.
    task automatic run_text_pass(input int unsigned len);
        logic [LETTER_W-1:0] cipher [$];
        logic [LETTER_W-1:0] plain [$];
        logic [LETTER_W-1:0] c;
        for (int unsigned i = 0; i < len; i++)
        begin
            c = random_cipher();
            cipher.push_back(c);
            plain.push_back(decrypt_letter(c));
        end
        for (int unsigned i = 3; i < len; i++)
        begin
            if (plain[i-3] < ALPHABET_SIZE && plain[i-2] < ALPHABET_SIZE &&
                plain[i-1] < ALPHABET_SIZE && plain[i] < ALPHABET_SIZE &&
                $urandom_range(0, 9) < 4)
                send_score(quad_address(plain[i-3], plain[i-2], plain[i-1], plain[i]),
                           random_score());
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                send_clear_best();
            send_text(cipher[i], i == len - 1);
        end
    endtask

    task automatic run_random_mix(input int unsigned count);
        int unsigned target;
        int unsigned roll;
        target = requests_sent + count;
        while (requests_sent < target)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    run_text_pass($urandom_range(1, 3));
                else if (roll < 95)
                    run_text_pass($urandom_range(4, 12));
                else
                    run_text_pass($urandom_range(20, 40));
            end
            else if (roll < 80)
                send_key(($urandom_range(0, 9) < 8) ? $urandom_range(0, ALPHABET_SIZE - 1)
                                                    : $urandom_range(0, 524287),
                         random_cipher());
            else if (roll < 90)
                send_score($urandom_range(0, 524287), $urandom);
            else if (roll < 95)
                send_clear_best();
            else
                send_text(random_cipher(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_directed();
        logic [LETTER_W-1:0] word_a [5];
        logic [LETTER_W-1:0] word_b [6];
        word_a = '{5'd0, 5'd1, 5'd2, 5'd25, 5'd0};
        word_b = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd2, 5'd26};
        source_busy = 1'b1;
        sink_busy = 1'b1;
        send_key(0, 5'd7);
        send_key(1, 5'd0);
        send_key(2, 5'd25);
        send_key(3, 5'd31);
        send_key(25, 5'd4);
        send_key(ALPHABET_SIZE, 5'd9);
        send_key(524287, 5'd9);
        send_score(quad_address(5'd7, 5'd0, 5'd25, 5'd4), 32'hFFFF_FFFF);
        send_score(quad_address(5'd0, 5'd25, 5'd4, 5'd7), 32'd1);
        send_score(QUAD_DEPTH, 32'h1234_5678);
        send_score(524287, 32'hFFFF_FFFF);
        send_score(0, 32'd0);
        send_text(5'd0, 1'b0);
        send_text(5'd1, 1'b1);
        send_text(5'd25, 1'b1);
        foreach (word_a[i])
            send_text(word_a[i], i == 4);
        foreach (word_a[i])
            send_text(word_a[i], i == 4);
        send_text(5'd0, 1'b0);
        send_text(5'd1, 1'b0);
        send_text(5'd2, 1'b0);
        send_clear_best();
        send_text(5'd25, 1'b1);
        foreach (word_b[i])
            send_text(word_b[i], i == 5);
    endtask

    task automatic test_back_to_back();
        source_busy = 1'b0;
        sink_busy = 1'b0;
        load_full_key();
        run_random_mix(200);
    endtask

    task automatic test_random_stalls();
        source_busy = 1'b1;
        sink_busy = 1'b1;
        run_random_mix(450);
    endtask

    initial
    begin
        key_letters = '{default: '0};
        recent_plain = '{default: '0};
        recent_count = 0;
        pass_total = '0;
        kept_best_total = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_to_back();
        test_random_stalls();
        s_axis_tvalid <= 1'b0;
        while (pending_letters.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Sent %0d requests; checked %0d letter results over %0d passes.",
                 requests_sent, letters_checked, passes_checked);
        $display("%0d passes beat the best total; back-to-back and stalled traffic both ran.",
                 new_best_count);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
